/* src/idws_pkg.sv */
// Shared types, constants and helper functions for the I2C display write serializer.
`timescale 1ns / 1ps

package idws_pkg;

	// Operation codes as they arrive on the input channel
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_CMD  = 2'd1;
	localparam logic [1:0] OP_DATA = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_DEV_ADDR  = 2'd0;
	localparam logic [1:0] CFG_CMD_CTRL  = 2'd1;
	localparam logic [1:0] CFG_DATA_CTRL = 2'd2;
	localparam logic [1:0] CFG_PHASE_TKS = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration reset values
	localparam logic [7:0]  RST_DEV_ADDR  = 8'h7A;
	localparam logic [7:0]  RST_CMD_CTRL  = 8'h00;
	localparam logic [7:0]  RST_DATA_CTRL = 8'h40;
	localparam logic [15:0] RST_PHASE_TKS = 16'd35;

	// Frame layout: start and stop are three phases each, every byte 21 phases
	localparam logic [4:0] SLOT_EDGE_LAST = 5'd2;
	localparam logic [4:0] SLOT_BYTE_LAST = 5'd20;
	localparam logic [4:0] SLOT_HOLD      = 5'd16;
	localparam logic [4:0] SLOT_ACK_HIGH  = 5'd18;
	localparam logic [4:0] SLOT_ACK_REL   = 5'd20;
	localparam logic [1:0] BYTE_LAST      = 2'd2;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_CMD,
		KIND_DATA,
		KIND_NOP
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload;
	} item_t;

	typedef enum logic [1:0] {
		SEG_IDLE,
		SEG_START,
		SEG_BYTE,
		SEG_STOP
	} seg_t;

	typedef struct packed {
		logic scl;
		logic sda;
		logic busy;
		logic done;
		logic rej;
	} result_t;

	// Byte of the latched frame by position (address, control, payload)
	function automatic logic [7:0] frame_byte(input logic [23:0] frame, input logic [1:0] sel);
		logic [7:0] b;
		case (sel)
			2'd0:    b = frame[23:16];
			2'd1:    b = frame[15:8];
			default: b = frame[7:0];
		endcase
		return b;
	endfunction

	// Line levels {scl, sda} for a phase
	function automatic logic [1:0] phase_lines(input seg_t seg, input logic [4:0] slot,
		input logic [7:0] b);
		logic [1:0] l;
		l = 2'b11;
		case (seg)
			SEG_START: begin
				l[1] = (slot != SLOT_EDGE_LAST);
				l[0] = (slot == 5'd0);
			end
			SEG_BYTE: begin
				if (slot < SLOT_HOLD) begin
					l[1] = slot[0];
					l[0] = b[~slot[3:1]];
				end else if (slot == SLOT_HOLD) begin
					l = {1'b0, b[0]};
				end else begin
					l[1] = (slot == SLOT_ACK_HIGH);
					l[0] = (slot == SLOT_ACK_REL);
				end
			end
			SEG_STOP: begin
				l[1] = (slot != 5'd0);
				l[0] = (slot == SLOT_EDGE_LAST);
			end
			default: l = 2'b11;
		endcase
		return l;
	endfunction

endpackage

/* src/idws_front.sv */
// Front end: input handshake and classification of operation codes.
`timescale 1ns / 1ps

module idws_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [7:0]         payload,
	input  logic               queue_full,
	output logic               push,
	output idws_pkg::item_t    item
);

	idws_pkg::kind_t kind;

	always_comb begin
		case (operation)
			idws_pkg::OP_TICK: kind = idws_pkg::KIND_TICK;
			idws_pkg::OP_CMD:  kind = idws_pkg::KIND_CMD;
			idws_pkg::OP_DATA: kind = idws_pkg::KIND_DATA;
			default:           kind = idws_pkg::KIND_NOP;
		endcase
	end

	assign in_ready     = !queue_full;
	assign push         = in_valid && !queue_full;
	assign item.kind    = kind;
	assign item.payload = payload;

endmodule

/* src/idws_queue.sv */
// Short FIFO of classified items between front and back.
`timescale 1ns / 1ps

module idws_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  idws_pkg::item_t item_in,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output idws_pkg::item_t head
);

	idws_pkg::item_t                     entry_q [idws_pkg::QUEUE_DEPTH];
	logic [idws_pkg::QUEUE_AW-1:0]       wr_ptr_q;
	logic [idws_pkg::QUEUE_AW-1:0]       rd_ptr_q;
	logic [idws_pkg::QUEUE_CW-1:0]       count_q;
	logic                                do_pop;

	localparam logic [idws_pkg::QUEUE_AW-1:0] PTR_LAST =
		idws_pkg::QUEUE_AW'(idws_pkg::QUEUE_DEPTH - 1);
	localparam logic [idws_pkg::QUEUE_CW-1:0] CNT_FULL =
		idws_pkg::QUEUE_CW'(idws_pkg::QUEUE_DEPTH);

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/idws_back.sv */
// Back end: configuration registers, phase sequencer and registered result.
`timescale 1ns / 1ps

module idws_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [idws_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [idws_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              head_valid,
	input  idws_pkg::item_t                   head,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output idws_pkg::result_t                 res
);

	// configuration
	logic [7:0]  dev_addr_q;
	logic [7:0]  cmd_ctrl_q;
	logic [7:0]  data_ctrl_q;
	logic [15:0] phase_ticks_q;

	// sequencer state
	idws_pkg::seg_t seg_q, seg_d;
	logic [4:0]     slot_q, slot_d;
	logic [1:0]     byte_q, byte_d;
	logic [15:0]    tick_q, tick_d;
	logic [23:0]    frame_q, frame_d;
	logic           scl_q, scl_d;
	logic           sda_q, sda_d;

	// output register
	logic              out_valid_q;
	idws_pkg::result_t res_q;

	logic              fire;
	logic              done_d;
	logic              rej_d;
	logic              relines;
	logic [15:0]       limit;
	logic [16:0]       tick_inc;
	logic [1:0]        lines;

	assign fire     = head_valid && (!out_valid_q || out_ready);
	assign pop      = fire;
	assign limit    = (phase_ticks_q == '0) ? 16'd1 : phase_ticks_q;
	assign tick_inc = {1'b0, tick_q} + 17'd1;
	assign lines    = idws_pkg::phase_lines(seg_d, slot_d,
		idws_pkg::frame_byte(frame_d, byte_d));
	assign scl_d    = relines ? lines[1] : scl_q;
	assign sda_d    = relines ? lines[0] : sda_q;

	always_comb begin
		seg_d   = seg_q;
		slot_d  = slot_q;
		byte_d  = byte_q;
		tick_d  = tick_q;
		frame_d = frame_q;
		done_d  = 1'b0;
		rej_d   = 1'b0;
		relines = 1'b0;
		if (fire) begin
			case (head.kind)
				idws_pkg::KIND_CMD, idws_pkg::KIND_DATA: begin
					if (seg_q != idws_pkg::SEG_IDLE) begin
						rej_d = 1'b1;
					end else begin
						frame_d = {dev_addr_q,
							(head.kind == idws_pkg::KIND_CMD) ? cmd_ctrl_q : data_ctrl_q,
							head.payload};
						seg_d   = idws_pkg::SEG_START;
						slot_d  = '0;
						byte_d  = '0;
						tick_d  = '0;
						relines = 1'b1;
					end
				end
				idws_pkg::KIND_TICK: begin
					if (seg_q != idws_pkg::SEG_IDLE) begin
						if (tick_inc >= {1'b0, limit}) begin
							tick_d  = '0;
							relines = 1'b1;
							case (seg_q)
								idws_pkg::SEG_START: begin
									if (slot_q == idws_pkg::SLOT_EDGE_LAST) begin
										seg_d  = idws_pkg::SEG_BYTE;
										slot_d = '0;
										byte_d = '0;
									end else begin
										slot_d = slot_q + 5'd1;
									end
								end
								idws_pkg::SEG_BYTE: begin
									if (slot_q != idws_pkg::SLOT_BYTE_LAST) begin
										slot_d = slot_q + 5'd1;
									end else if (byte_q == idws_pkg::BYTE_LAST) begin
										seg_d  = idws_pkg::SEG_STOP;
										slot_d = '0;
									end else begin
										byte_d = byte_q + 2'd1;
										slot_d = '0;
									end
								end
								idws_pkg::SEG_STOP: begin
									if (slot_q == idws_pkg::SLOT_EDGE_LAST) begin
										seg_d  = idws_pkg::SEG_IDLE;
										slot_d = '0;
										byte_d = '0;
										done_d = 1'b1;
									end else begin
										slot_d = slot_q + 5'd1;
									end
								end
								default: seg_d = idws_pkg::SEG_IDLE;
							endcase
						end else begin
							tick_d = tick_inc[15:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q    <= idws_pkg::RST_DEV_ADDR;
			cmd_ctrl_q    <= idws_pkg::RST_CMD_CTRL;
			data_ctrl_q   <= idws_pkg::RST_DATA_CTRL;
			phase_ticks_q <= idws_pkg::RST_PHASE_TKS;
		end else if (cfg_we) begin
			case (cfg_index)
				idws_pkg::CFG_DEV_ADDR:  dev_addr_q    <= cfg_wdata[7:0];
				idws_pkg::CFG_CMD_CTRL:  cmd_ctrl_q    <= cfg_wdata[7:0];
				idws_pkg::CFG_DATA_CTRL: data_ctrl_q   <= cfg_wdata[7:0];
				idws_pkg::CFG_PHASE_TKS: phase_ticks_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q   <= idws_pkg::SEG_IDLE;
			slot_q  <= '0;
			byte_q  <= '0;
			tick_q  <= '0;
			frame_q <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
		end else begin
			seg_q   <= seg_d;
			slot_q  <= slot_d;
			byte_q  <= byte_d;
			tick_q  <= tick_d;
			frame_q <= frame_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.scl  <= scl_d;
			res_q.sda  <= sda_d;
			res_q.busy <= (seg_d != idws_pkg::SEG_IDLE);
			res_q.done <= done_d;
			res_q.rej  <= rej_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	// end of frame always releases both lines
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done |-> !res_q.busy && res_q.scl && res_q.sda)
		else $error("frame end without released lines");

	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.rej |-> res_q.busy && !res_q.done)
		else $error("reject reported while idle");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_q == idws_pkg::SEG_START || seg_q == idws_pkg::SEG_STOP) |->
		slot_q <= idws_pkg::SLOT_EDGE_LAST)
		else $error("edge phase slot out of range");

	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		seg_q == idws_pkg::SEG_BYTE |->
		slot_q <= idws_pkg::SLOT_BYTE_LAST && byte_q <= idws_pkg::BYTE_LAST)
		else $error("byte phase out of range");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		seg_q == idws_pkg::SEG_IDLE |-> tick_q == '0 && slot_q == '0)
		else $error("counters not cleared while idle");

endmodule

/* src/i2c_display_write_serializer.sv */
// Top level of the write-only I2C display serializer.
`timescale 1ns / 1ps

// Write-only I2C transmitter for a display controller. Each input transfer is
// either a tick (operation 0), a command byte request (1) or a data byte request
// (2); code 3 is a no-op. Every input transfer yields exactly one output transfer
// carrying the scl/sda levels after that item, busy_res, frame_done (set on the
// tick that ends the stop phase) and rejected (a request that arrived mid-frame).
// A request taken while idle latches {device_address_byte, control byte, payload}
// and starts a fixed 69-phase frame: start, three bytes MSB first each with a
// hold phase and a never-sampled ack slot driven low, then stop. Every phase lasts
// phase_ticks ticks (0 acts as 1). Throughput is one item per clock: the front
// end classifies and pushes into a two-entry queue, the back end sequencer
// retires one queued item per cycle into an output register, so results flow
// back to back as long as out_ready stays high. Each result is registered: an
// input item is written into a queue entry, then fired into the output register.
// With out_ready held low, the output register and the two queue entries
// absorb three transfers before in_ready drops. Configuration writes (cfg_we,
// cfg_index, cfg_wdata) take effect at once; write them only while no transfer
// is in flight. A frame may still be running: its bytes are latched, while
// phase_ticks is read live.
module i2c_display_write_serializer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [idws_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [idws_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       operation,
	input  logic [7:0]                       payload,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             scl,
	output logic                             sda,
	output logic                             busy_res,
	output logic                             frame_done,
	output logic                             rejected
);

	idws_pkg::item_t   push_item;
	idws_pkg::item_t   head;
	idws_pkg::result_t res;
	logic              push;
	logic              queue_full;
	logic              head_valid;
	logic              pop;

	// decode and input handshake
	idws_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.payload    (payload),
		.queue_full (queue_full),
		.push       (push),
		.item       (push_item)
	);

	// decouples input acceptance from output backpressure
	idws_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item_in    (push_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// phase sequencer, config registers, output register
	idws_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res        (res)
	);

	assign scl        = res.scl;
	assign sda        = res.sda;
	assign busy_res   = res.busy;
	assign frame_done = res.done;
	assign rejected   = res.rej;

endmodule
